/* hdl/lmp_pkg.sv */
`timescale 1ns / 1ps

package lmp_pkg;

    localparam int SYM_W  = 8;
    localparam int WGT_W  = 16;
    localparam int PROD_W = SYM_W + WGT_W;
    localparam int SUM_W  = 25;
    localparam int PORT_W = 2;
    localparam int CNT_W  = 3;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    // Output queue: depth, pointer and occupancy widths.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef enum logic {
        OP_WEIGHT = 1'b0,
        OP_SYMBOL = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_LAYER_COUNT = 1'b0,
        REG_PORT_COUNT  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic              first;
        logic              last;
        logic [PORT_W-1:0] port;
        logic              last_port;
    } lmp_tag_t;

    typedef struct packed {
        logic [PORT_W-1:0]       port;
        logic signed [SUM_W-1:0] re;
        logic signed [SUM_W-1:0] im;
        logic                    last_port;
    } lmp_result_t;

endpackage

/* hdl/lmp_mac.sv */
`timescale 1ns / 1ps

module lmp_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    input  lmp_pkg::lmp_tag_t                  in_tag,
    input  logic [2*lmp_pkg::SYM_W-1:0]        in_sym,
    input  logic [2*lmp_pkg::WGT_W-1:0]        in_wgt,
    output logic                               out_valid,
    output lmp_pkg::lmp_result_t               out_result
);
    import lmp_pkg::*;

    logic signed [SYM_W-1:0]  sym_a;
    logic signed [SYM_W-1:0]  sym_b;
    logic signed [WGT_W-1:0]  wgt_c;
    logic signed [WGT_W-1:0]  wgt_d;

    logic signed [PROD_W-1:0] ac_reg;
    logic signed [PROD_W-1:0] bd_reg;
    logic signed [PROD_W-1:0] ad_reg;
    logic signed [PROD_W-1:0] bc_reg;
    logic                     prod_valid_reg;
    lmp_tag_t                 prod_tag_reg;

    logic signed [SUM_W-1:0]  acc_re_reg;
    logic signed [SUM_W-1:0]  acc_im_reg;
    logic signed [SUM_W-1:0]  acc_re_next;
    logic signed [SUM_W-1:0]  acc_im_next;
    logic signed [SUM_W-1:0]  base_re;
    logic signed [SUM_W-1:0]  base_im;

    assign sym_a = $signed(in_sym[2*SYM_W-1:SYM_W]);
    assign sym_b = $signed(in_sym[SYM_W-1:0]);
    assign wgt_c = $signed(in_wgt[2*WGT_W-1:WGT_W]);
    assign wgt_d = $signed(in_wgt[WGT_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= in_valid;
        end
        prod_tag_reg <= in_tag;
        ac_reg       <= sym_a * wgt_c;
        bd_reg       <= sym_b * wgt_d;
        ad_reg       <= sym_a * wgt_d;
        bc_reg       <= sym_b * wgt_c;
    end

    // The accumulator keeps only the low bits of the sum, so it wraps the same
    // way as a full-width sum truncated at the end.
    always_comb begin
        base_re     = prod_tag_reg.first ? '0 : acc_re_reg;
        base_im     = prod_tag_reg.first ? '0 : acc_im_reg;
        acc_re_next = base_re + SUM_W'(ac_reg) - SUM_W'(bd_reg);
        acc_im_next = base_im + SUM_W'(ad_reg) + SUM_W'(bc_reg);
    end

    always_ff @(posedge aclk) begin
        if (prod_valid_reg) begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    assign out_valid            = prod_valid_reg && prod_tag_reg.last;
    assign out_result.port      = prod_tag_reg.port;
    assign out_result.re        = acc_re_next;
    assign out_result.im        = acc_im_next;
    assign out_result.last_port = prod_tag_reg.last_port;

endmodule

/* hdl/layer_map_and_precode_core.sv */
`timescale 1ns / 1ps
// The first port result of an element, after the symbol that completes it,
// passes the state register, the memory read registers, the product registers
// and the result queue; each further layer adds a read. An element holds both
// memories for layers*ports reads, one weight read per cycle while credit lasts.
// Reset clears counters, configuration (both counts to 1) and the output queue;
// the weight and symbol memories are not cleared.
module layer_map_and_precode_core #(
    parameter int MAX_LAYERS = 4,
    parameter int MAX_PORTS  = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  lmp_pkg::cfg_index_t                 cfg_index,
    input  logic [lmp_pkg::CNT_W-1:0]           cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // symbol_re, symbol_im, port_index, layer_index, weight_re, weight_im
    input  logic [lmp_pkg::S_TDATA_W-1:0]       s_tdata,
    // opcode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_re, out_im
    output logic [lmp_pkg::M_TDATA_W-1:0]       m_tdata,
    // out_port
    output logic [lmp_pkg::PORT_W-1:0]          m_tuser,
    output logic                                m_tlast
);
    import lmp_pkg::*;

    localparam int LIW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int PIW    = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int LCW    = $clog2(MAX_LAYERS + 1);
    localparam int PCW    = $clog2(MAX_PORTS + 1);
    localparam int WDEPTH = MAX_PORTS * MAX_LAYERS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    function automatic int clamp_count(input logic [CNT_W-1:0] v, input int maxv);
        if (v == '0) begin
            return 1;
        end else if (int'(v) > maxv) begin
            return maxv;
        end else begin
            return int'(v);
        end
    endfunction

    // Input fields
    logic [SYM_W-1:0]  in_sym_re;
    logic [SYM_W-1:0]  in_sym_im;
    logic [1:0]        in_port;
    logic [1:0]        in_layer;
    logic [WGT_W-1:0]  in_wgt_re;
    logic [WGT_W-1:0]  in_wgt_im;

    assign in_sym_re = s_tdata[7:0];
    assign in_sym_im = s_tdata[15:8];
    assign in_port   = s_tdata[17:16];
    assign in_layer  = s_tdata[19:18];
    assign in_wgt_re = s_tdata[35:20];
    assign in_wgt_im = s_tdata[51:36];

    // Control state
    state_t               state_reg, state_next;
    logic [LCW-1:0]       layers_reg;
    logic [PCW-1:0]       ports_reg;
    logic [LIW-1:0]       pos_reg, pos_next;
    logic [LIW-1:0]       l_reg, l_next;
    logic [PIW-1:0]       p_reg, p_next;
    logic [OUT_CNT_W-1:0] credit_reg, credit_next;

    logic [LIW-1:0] last_layer_idx;
    logic [PIW-1:0] last_port_idx;
    logic           at_last_layer;
    logic           at_last_port;
    logic           issue;
    logic           issue_done;
    logic           take;
    logic           s_xfer;
    logic           is_symbol;
    logic           complete;
    logic           pop;

    // Memories and their read registers
    logic [2*SYM_W-1:0] sym_mem [MAX_LAYERS];
    logic [2*WGT_W-1:0] wgt_mem [WDEPTH];
    logic [2*SYM_W-1:0] sym_rd_reg;
    logic [2*WGT_W-1:0] wgt_rd_reg;
    logic               rd_valid_reg;
    lmp_tag_t           rd_tag_reg;
    lmp_tag_t           issue_tag;
    logic [LIW-1:0]     sym_wr_addr;
    logic               wgt_we;
    logic [WAW-1:0]     wgt_wr_addr;
    logic [WAW-1:0]     wgt_rd_addr;

    // Result queue
    logic                 push;
    lmp_result_t          push_data;
    lmp_result_t          fifo_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    lmp_result_t          head;

    assign last_layer_idx = LIW'(int'(layers_reg) - 1);
    assign last_port_idx  = PIW'(int'(ports_reg) - 1);
    assign at_last_layer  = (l_reg == last_layer_idx);
    assign at_last_port   = (p_reg == last_port_idx);

    // A port starts only when a queue slot is reserved for its result, so the
    // read pipeline never has to stall.
    assign issue      = (state_reg == ST_RUN) && ((l_reg != '0) || (credit_reg != '0));
    assign issue_done = issue && at_last_layer && at_last_port;
    assign take       = issue && (l_reg == '0);

    // The next item is taken during the last read cycle of an element; reads
    // see the memory contents from before that edge.
    assign s_tready  = (state_reg == ST_IDLE) || issue_done;
    assign s_xfer    = s_tvalid && s_tready;
    assign is_symbol = (s_tuser == OP_SYMBOL);
    assign complete  = s_xfer && is_symbol && (int'(pos_reg) + 1 >= int'(layers_reg));

    assign pop = m_tvalid && m_tready;

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        l_next      = l_reg;
        p_next      = p_reg;
        credit_next = credit_reg + OUT_CNT_W'(pop) - OUT_CNT_W'(take);

        case (state_reg)
            ST_IDLE: begin
                if (complete) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue_done) begin
                    state_next = complete ? ST_RUN : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (issue) begin
            if (at_last_layer) begin
                l_next = '0;
                p_next = at_last_port ? '0 : p_reg + PIW'(1);
            end else begin
                l_next = l_reg + LIW'(1);
            end
        end

        if (cfg_we && (cfg_index == REG_LAYER_COUNT)) begin
            pos_next = '0;
        end else if (s_xfer && is_symbol) begin
            pos_next = complete ? '0 : pos_reg + LIW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            layers_reg <= LCW'(1);
            ports_reg  <= PCW'(1);
            pos_reg    <= '0;
            l_reg      <= '0;
            p_reg      <= '0;
            credit_reg <= OUT_CNT_W'(OUT_DEPTH);
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            l_reg      <= l_next;
            p_reg      <= p_next;
            credit_reg <= credit_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_LAYER_COUNT: layers_reg <= LCW'(clamp_count(cfg_data, MAX_LAYERS));
                    REG_PORT_COUNT:  ports_reg  <= PCW'(clamp_count(cfg_data, MAX_PORTS));
                    default: begin
                    end
                endcase
            end
        end
    end

    // Memory write and read
    assign sym_wr_addr = complete ? last_layer_idx : pos_reg;
    assign wgt_we      = s_xfer && !is_symbol && (int'(in_port) < MAX_PORTS)
                         && (int'(in_layer) < MAX_LAYERS);
    assign wgt_wr_addr = WAW'(int'(in_port) * MAX_LAYERS + int'(in_layer));
    assign wgt_rd_addr = WAW'(int'(p_reg) * MAX_LAYERS + int'(l_reg));

    always_ff @(posedge aclk) begin
        if (s_xfer && is_symbol) begin
            sym_mem[sym_wr_addr] <= {in_sym_re, in_sym_im};
        end
        if (wgt_we) begin
            wgt_mem[wgt_wr_addr] <= {in_wgt_re, in_wgt_im};
        end
        if (issue) begin
            sym_rd_reg <= sym_mem[l_reg];
            wgt_rd_reg <= wgt_mem[wgt_rd_addr];
        end
    end

    assign issue_tag.first     = (l_reg == '0);
    assign issue_tag.last      = at_last_layer;
    assign issue_tag.port      = PORT_W'(p_reg);
    assign issue_tag.last_port = at_last_port;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= issue;
        end
        rd_tag_reg <= issue_tag;
    end

    lmp_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (rd_valid_reg),
        .in_tag     (rd_tag_reg),
        .in_sym     (sym_rd_reg),
        .in_wgt     (wgt_rd_reg),
        .out_valid  (push),
        .out_result (push_data)
    );

    // Result queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            count_reg <= count_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{(M_TDATA_W - 2*SUM_W){1'b0}}, head.im, head.re};
    assign m_tuser  = head.port;
    assign m_tlast  = head.last_port;

endmodule

/* verif/precode_checker.sv */
`timescale 1ns / 1ps

module precode_checker #(
    parameter int MAX_LAYERS = 4,
    parameter int MAX_PORTS  = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  lmp_pkg::cfg_index_t               cfg_index,
    input  logic [lmp_pkg::CNT_W-1:0]         cfg_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [lmp_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [lmp_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic [lmp_pkg::PORT_W-1:0]        m_tuser,
    input  logic                              m_tlast,
    output int                                mismatches,
    output int                                samples_owed
);
    import lmp_pkg::*;

    // Shadow of the block: gathered layer symbols, weight table, counts.
    logic signed [SYM_W-1:0] sym_re_buf [MAX_LAYERS];
    logic signed [SYM_W-1:0] sym_im_buf [MAX_LAYERS];
    logic signed [WGT_W-1:0] wgt_re_tbl [MAX_PORTS][MAX_LAYERS];
    logic signed [WGT_W-1:0] wgt_im_tbl [MAX_PORTS][MAX_LAYERS];
    logic [CNT_W-1:0]        layer_reg;
    logic [CNT_W-1:0]        port_reg;
    int unsigned             gather_pos;
    lmp_result_t             owed_samples [$];

    initial begin
        mismatches   = 0;
        samples_owed = 0;
    end

    function automatic int unsigned clamp_count(logic [CNT_W-1:0] v, int unsigned max);
        if (v == 0)
            return 1;
        return (v > max) ? max : v;
    endfunction

    task automatic report(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", what);
    endtask

    // Update the shadow state with one accepted input and queue the port
    // samples that it completes.
    task automatic precode_take_item(opcode_t op, logic [S_TDATA_W-1:0] d);
        int unsigned       layers;
        int unsigned       ports;
        logic signed [63:0] acc_re;
        logic signed [63:0] acc_im;
        lmp_result_t       r;
        layers = clamp_count(layer_reg, MAX_LAYERS);
        ports  = clamp_count(port_reg, MAX_PORTS);
        if (op == OP_WEIGHT) begin
            wgt_re_tbl[d[17:16]][d[19:18]] = d[35:20];
            wgt_im_tbl[d[17:16]][d[19:18]] = d[51:36];
            return;
        end
        sym_re_buf[(gather_pos + 1 < layers) ? gather_pos : layers - 1] = d[7:0];
        sym_im_buf[(gather_pos + 1 < layers) ? gather_pos : layers - 1] = d[15:8];
        if (gather_pos + 1 < layers) begin
            gather_pos++;
            return;
        end
        gather_pos = 0;
        for (int p = 0; p < ports; p++) begin
            acc_re = 0;
            acc_im = 0;
            for (int l = 0; l < layers; l++) begin
                acc_re = acc_re + sym_re_buf[l] * wgt_re_tbl[p][l]
                                - sym_im_buf[l] * wgt_im_tbl[p][l];
                acc_im = acc_im + sym_re_buf[l] * wgt_im_tbl[p][l]
                                + sym_im_buf[l] * wgt_re_tbl[p][l];
            end
            // Sums wrap to the output width, no saturation.
            r.port      = p[PORT_W-1:0];
            r.re        = acc_re[SUM_W-1:0];
            r.im        = acc_im[SUM_W-1:0];
            r.last_port = (p + 1 == ports);
            owed_samples.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        lmp_result_t got;
        lmp_result_t want;
        if (!aresetn) begin
            layer_reg  = 1;
            port_reg   = 1;
            gather_pos = 0;
            owed_samples.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_LAYER_COUNT) begin
                    layer_reg  = cfg_data;
                    gather_pos = 0;
                end else begin
                    port_reg = cfg_data;
                end
            end
            if (m_tvalid && m_tready) begin
                got.port      = m_tuser;
                got.re        = m_tdata[SUM_W-1:0];
                got.im        = m_tdata[2*SUM_W-1:SUM_W];
                got.last_port = m_tlast;
                if (owed_samples.size() == 0) begin
                    report($sformatf("unexpected sample: port %0d re %0d im %0d last %0b",
                                     got.port, got.re, got.im, got.last_port));
                end else begin
                    want = owed_samples.pop_front();
                    if (got !== want)
                        report($sformatf({"sample mismatch: expected port %0d re %0d im %0d ",
                                          "last %0b, got port %0d re %0d im %0d last %0b"},
                                         want.port, want.re, want.im, want.last_port,
                                         got.port, got.re, got.im, got.last_port));
                end
            end
            if (s_tvalid && s_tready)
                precode_take_item(opcode_t'(s_tuser), s_tdata);
        end
        samples_owed = owed_samples.size();
    end

endmodule

/* verif/tb_layer_map_and_precode_core.sv */
`timescale 1ns / 1ps

module tb_layer_map_and_precode_core;
    import lmp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 12;

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    cfg_index_t              cfg_index = REG_LAYER_COUNT;
    logic [CNT_W-1:0]        cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic                    s_tuser   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [PORT_W-1:0]       m_tuser;
    logic                    m_tlast;

    int mismatches;
    int samples_owed;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;

    layer_map_and_precode_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    precode_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .samples_owed (samples_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Result side: random stalls, plus long hold-offs on request so that the
    // block backs up and stalls its input.
    initial begin
        forever begin
            @(negedge aclk);
            if (holds_served < hold_requests) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_item(logic [7:0] sym_re, logic [7:0] sym_im,
                                                       logic [1:0] port_idx, logic [1:0] layer_idx,
                                                       logic [15:0] w_re, logic [15:0] w_im);
        return {4'b0, w_im, w_re, layer_idx, port_idx, sym_im, sym_re};
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer,
    // with tvalid still high so a following item can go out back to back.
    task automatic send_item(opcode_t op, logic [S_TDATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_symbol(logic [7:0] sym_re, logic [7:0] sym_im);
        send_item(OP_SYMBOL, pack_item(sym_re, sym_im, 2'($urandom), 2'($urandom),
                                       16'($urandom), 16'($urandom)));
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop sending and let every owed sample drain, then give any partial
    // element work time to finish before the block is reconfigured.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (samples_owed != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [7:0] rand_symbol_part();
        case ($urandom_range(9))
            0:       return 8'h80;
            1:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [15:0] w_re;
        logic signed [15:0] w_im;
        logic [CNT_W-1:0]   layer_set [PHASES];
        logic [CNT_W-1:0]   port_set  [PHASES];
        int                 send_set  [PHASES];
        int                 recv_set  [PHASES];
        layer_set = '{3'd1, 3'd4, 3'd2, 3'd3, 3'd0, 3'd7, 3'd4, 3'd2};
        port_set  = '{3'd4, 3'd4, 3'd3, 3'd1, 3'd7, 3'd0, 3'd2, 3'd2};
        send_set  = '{0, 87, 0, 16, 0, 87, 0, 16};
        recv_set  = '{0, 0, 87, 16, 0, 0, 87, 16};

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. Every weight is written first so no element ever
        // reads an entry that was never written.
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        for (int p = 0; p < 4; p++) begin
            for (int l = 0; l < 4; l++) begin
                case (p)
                    0: begin
                        w_re = -16'sd32768;
                        w_im = 16'sd32767;
                    end
                    1: begin
                        w_re = 16'sd32767;
                        w_im = -16'sd32768;
                    end
                    2: begin
                        w_re = (l == 0) ? 16'sd16384 : (l == 2) ? -16'sd16384 : 16'sd0;
                        w_im = (l == 1) ? 16'sd16384 : (l == 3) ? -16'sd16384 : 16'sd0;
                    end
                    default: begin
                        w_re = (l == 1) ? 16'sd1 : -16'sd1;
                        w_im = (l == 3) ? 16'sd32767 : (l == 1) ? 16'sd1 : -16'sd1;
                    end
                endcase
                send_item(OP_WEIGHT, pack_item(8'($urandom), 8'($urandom), 2'(p), 2'(l),
                                               w_re, w_im));
            end
        end
        // Reset counts: one layer, one port.
        send_symbol(8'h80, 8'h80);
        send_symbol(8'h7F, 8'h80);
        settle();

        // Four layers of the most negative symbol against extreme weights:
        // the sums overflow the output width and must wrap.
        write_reg(REG_LAYER_COUNT, 3'd4);
        write_reg(REG_PORT_COUNT, 3'd4);
        repeat (4) send_symbol(8'h80, 8'h80);
        // A partial element, dropped by the next layer count write.
        send_symbol(8'h7F, 8'h7F);
        send_symbol(8'h00, 8'h00);
        settle();

        // Random part, one configuration and idle pattern per phase.
        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(REG_LAYER_COUNT, layer_set[ph]);
            write_reg(REG_PORT_COUNT, port_set[ph]);
            send_idle_pct  = send_set[ph];
            recv_stall_pct = recv_set[ph];
            if (ph == 0)
                hold_requests++;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(9) == 0)
                    send_item(OP_WEIGHT, pack_item(8'($urandom), 8'($urandom),
                                                   2'($urandom), 2'($urandom),
                                                   16'($urandom), 16'($urandom)));
                else
                    send_symbol(rand_symbol_part(), rand_symbol_part());
            end
            settle();
        end

        if (mismatches == 0 && samples_owed == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
